FILE: hdl/dsks_pkg.sv
package dsks_pkg;

   // Fixed geometry of the engine.
   localparam int SECTOR_BYTES      = 256;
   localparam int SECTOR_COUNT_BITS = 16;
   localparam int ARG_DEPTH         = 256;
   localparam int QUEUE_DEPTH       = 2;
   localparam int CSR_ADDR_BITS     = 5;
   localparam int CSR_DATA_BITS     = 32;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_DATA  = 2'd1,
      ACT_START = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      REL_EQUAL      = 2'd0,
      REL_LOW_EQUAL  = 2'd1,
      REL_HIGH_EQUAL = 2'd2,
      REL_REFUSED    = 2'd3
   } relation_type;

   typedef enum logic [1:0] {
      SIGN_EQUAL = 2'd0,
      SIGN_LOW   = 2'd1,
      SIGN_HIGH  = 2'd2
   } sign_type;

   typedef enum logic [2:0] {
      ST_NO_HIT        = 3'd0,
      ST_HIT_EQUAL     = 3'd1,
      ST_HIT_NOT_EQUAL = 3'd2,
      ST_DONE_NO_HIT   = 3'd3,
      ST_REFUSED       = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      REG_FIRST_KEY    = 3'd0,
      REG_KEY_LENGTH   = 3'd1,
      REG_LAST_KEY     = 3'd2,
      REG_KEY_GAP      = 3'd3,
      REG_RELATION     = 3'd4,
      REG_SCAN_SECTORS = 3'd5
   } reg_index_type;

   typedef struct packed {
      action_type action;
      logic [7:0] argument_index;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  hit_offset;
      logic [15:0] sector_offset;
   } rsp_item_type;

   // Register contents shared by the front and back parts.
   typedef struct packed {
      logic [7:0]   first_key;
      logic [7:0]   key_length_minus_one;
      logic [7:0]   last_key;
      logic [7:0]   key_gap;
      relation_type relation;
      logic [15:0]  scan_sectors_minus_one;
   } cfg_type;

   // One classified item handed from the front part to the back part.
   typedef struct packed {
      action_type action;
      logic [7:0] data_byte;
      logic       key_active;
      logic       key_start;
      logic       key_end;
      logic [7:0] byte_pos;
      logic       sector_last;
      logic [7:0] arg_byte;
   } work_item_type;

   function automatic logic relation_met(relation_type rel, sign_type sign);
      logic met;
      case (rel)
         REL_EQUAL:      met = (sign == SIGN_EQUAL);
         REL_LOW_EQUAL:  met = (sign != SIGN_HIGH);
         REL_HIGH_EQUAL: met = (sign != SIGN_LOW);
         default:        met = 1'b0;
      endcase
      return met;
   endfunction

endpackage

FILE: hdl/dsks_ram.sv
module dsks_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/dsks_fifo.sv
module dsks_fifo #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [Width-1:0] wr_data,
   output logic             is_full,
   input  logic             rd_en,
   output logic [Width-1:0] rd_data,
   output logic             is_empty
);

   localparam int PtrBits   = $clog2(Depth);
   localparam int CountBits = $clog2(Depth + 1);

   logic [Width-1:0]     slot_ff [Depth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 do_wr, do_rd;

   assign is_full  = (count_ff == CountBits'(Depth));
   assign is_empty = (count_ff == '0);
   assign do_wr    = wr_en && !is_full;
   assign do_rd    = rd_en && !is_empty;
   assign rd_data  = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots need no reset.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hdl/dsks_front.sv
module dsks_front (
   input  logic                   clock,
   input  logic                   reset,
   input  dsks_pkg::cfg_type      cfg,
   input  logic                   push,
   output logic                   full,
   input  dsks_pkg::req_item_type req_item,
   output logic                   work_push,
   output dsks_pkg::work_item_type work_item,
   input  logic                   work_full
);
   import dsks_pkg::*;

   // Key position tracking.
   logic [7:0]  pos_ff, pos_in;
   logic [8:0]  next_start_ff, next_start_in;
   logic        in_key_ff, in_key_in;
   logic [8:0]  key_index_ff, key_index_in;

   // Classified item waiting for its argument byte.
   logic          held_valid_ff, held_valid_in;
   work_item_type held_ff, held_in;

   logic        accept;
   logic [8:0]  key_len;
   logic [9:0]  key_fit_sum;
   logic [10:0] next_sum;
   logic        key_start;
   logic        key_active;
   logic [8:0]  key_index;
   logic [8:0]  key_index_next;
   logic        key_end;
   logic        arg_wr;
   logic        arg_rd;
   logic [7:0]  arg_data;

   assign full      = held_valid_ff && work_full;
   assign accept    = push && !full;
   assign work_push = held_valid_ff && !work_full;
   assign arg_wr    = accept && (req_item.action == ACT_LOAD);
   assign arg_rd    = accept && (req_item.action == ACT_DATA);

   // The held item leaves with the argument byte read at its acceptance.
   always_comb begin
      work_item          = held_ff;
      work_item.arg_byte = arg_data;
   end

   // Where the current sector byte falls relative to the keys.
   assign key_len        = {1'b0, cfg.key_length_minus_one} + 9'd1;
   assign key_fit_sum    = {1'b0, next_start_ff} + {1'b0, key_len};
   assign key_start      = !in_key_ff && ({1'b0, pos_ff} == next_start_ff)
                           && (next_start_ff <= {1'b0, cfg.last_key})
                           && (key_fit_sum <= 10'(SECTOR_BYTES));
   assign key_active     = in_key_ff || key_start;
   assign key_index      = key_start ? 9'd0 : key_index_ff;
   assign key_index_next = key_index + 9'd1;
   assign key_end        = key_active && (key_index_next >= key_len);
   assign next_sum       = {2'b00, next_start_ff} + {2'b00, key_len}
                           + {3'b000, cfg.key_gap};

   always_comb begin
      pos_in        = pos_ff;
      next_start_in = next_start_ff;
      in_key_in     = in_key_ff;
      key_index_in  = key_index_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;

      if (work_push) begin
         held_valid_in = 1'b0;
      end

      if (accept) begin
         held_valid_in       = 1'b1;
         held_in.action      = req_item.action;
         held_in.data_byte   = req_item.data_byte;
         held_in.key_active  = key_active;
         held_in.key_start   = key_start;
         held_in.key_end     = key_end;
         held_in.byte_pos    = pos_ff;
         held_in.sector_last = (pos_ff == 8'(SECTOR_BYTES - 1));
         held_in.arg_byte    = '0;

         case (req_item.action)
            ACT_START: begin
               pos_in        = '0;
               next_start_in = {1'b0, cfg.first_key};
               in_key_in     = 1'b0;
               key_index_in  = '0;
            end
            ACT_DATA: begin
               // Step through the key, then on to the next key start.
               if (key_active) begin
                  if (key_end) begin
                     in_key_in     = 1'b0;
                     next_start_in = (next_sum > 11'd511) ? 9'd511 : next_sum[8:0];
                  end else begin
                     in_key_in    = 1'b1;
                     key_index_in = key_index_next;
                  end
               end
               // Sector end restarts the key layout.
               if (pos_ff == 8'(SECTOR_BYTES - 1)) begin
                  pos_in        = '0;
                  next_start_in = {1'b0, cfg.first_key};
                  in_key_in     = 1'b0;
                  key_index_in  = '0;
               end else begin
                  pos_in = pos_ff + 8'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         next_start_ff <= '0;
         in_key_ff     <= 1'b0;
         key_index_ff  <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         next_start_ff <= next_start_in;
         in_key_ff     <= in_key_in;
         key_index_ff  <= key_index_in;
         held_valid_ff <= held_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   // Search argument store; a sector byte reads the entry for its key position.
   dsks_ram #(
      .Width (8),
      .Depth (ARG_DEPTH)
   ) u_arg_ram (
      .clock   (clock),
      .wr_en   (arg_wr),
      .wr_addr (req_item.argument_index),
      .wr_data (req_item.data_byte),
      .rd_en   (arg_rd),
      .rd_addr (key_index[7:0]),
      .rd_data (arg_data)
   );

endmodule

FILE: hdl/dsks_back.sv
module dsks_back #(
   parameter int SectorCountBits = dsks_pkg::SECTOR_COUNT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dsks_pkg::cfg_type       cfg,
   input  logic                    work_empty,
   input  dsks_pkg::work_item_type work_item,
   output logic                    work_pop,
   output logic                    rsp_push,
   output dsks_pkg::rsp_item_type  rsp_data,
   input  logic                    rsp_full
);
   import dsks_pkg::*;

   localparam int CmpBits = (SectorCountBits > 16) ? SectorCountBits : 16;

   logic                       scan_ff, scan_in;
   sign_type                   sign_ff, sign_in;
   logic                       hit_ff, hit_in;
   logic                       hit_equal_ff, hit_equal_in;
   logic [7:0]                 hit_pos_ff, hit_pos_in;
   logic [SectorCountBits-1:0] count_ff, count_in;

   logic         take;
   logic         result_valid;
   rsp_item_type result;
   sign_type     sign_eff;
   logic [9:0]   geometry_sum;
   logic         last_sector;
   logic [CmpBits-1:0] count_wide;

   assign take         = !work_empty && !rsp_full;
   assign work_pop     = take;
   assign rsp_push     = take && result_valid;
   assign rsp_data     = result;
   assign geometry_sum = {2'b00, cfg.first_key} + {2'b00, cfg.key_length_minus_one} + 10'd1;
   assign count_wide   = CmpBits'(count_ff);
   assign last_sector  = (count_wide == CmpBits'(cfg.scan_sectors_minus_one));

   always_comb begin
      scan_in      = scan_ff;
      sign_in      = sign_ff;
      hit_in       = hit_ff;
      hit_equal_in = hit_equal_ff;
      hit_pos_in   = hit_pos_ff;
      count_in     = count_ff;
      result_valid = 1'b0;
      result       = '0;
      sign_eff     = work_item.key_start ? SIGN_EQUAL : sign_ff;

      if (take) begin
         case (work_item.action)
            ACT_START: begin
               // Refuse a bad relation or a first key that overruns the sector.
               if (cfg.relation == REL_REFUSED || geometry_sum > 10'(SECTOR_BYTES)) begin
                  scan_in       = 1'b0;
                  result_valid  = 1'b1;
                  result.status = ST_REFUSED;
               end else begin
                  scan_in      = 1'b1;
                  hit_in       = 1'b0;
                  hit_equal_in = 1'b0;
                  hit_pos_in   = '0;
                  count_in     = '0;
                  sign_in      = SIGN_EQUAL;
               end
            end
            ACT_DATA: begin
               if (scan_ff) begin
                  // Byte compare until the first difference decides the key.
                  if (work_item.key_active && !hit_ff) begin
                     if (sign_eff == SIGN_EQUAL) begin
                        if (work_item.data_byte < work_item.arg_byte) begin
                           sign_eff = SIGN_LOW;
                        end else if (work_item.data_byte > work_item.arg_byte) begin
                           sign_eff = SIGN_HIGH;
                        end
                     end
                     sign_in = sign_eff;
                     if (work_item.key_end && relation_met(cfg.relation, sign_eff)) begin
                        hit_in       = 1'b1;
                        hit_equal_in = (sign_eff == SIGN_EQUAL);
                        hit_pos_in   = work_item.byte_pos;
                     end
                  end

                  // Sector end reports and either goes on or idles.
                  if (work_item.sector_last) begin
                     result_valid         = 1'b1;
                     result.sector_offset = count_wide[15:0];
                     sign_in              = SIGN_EQUAL;
                     if (hit_in) begin
                        result.status     = hit_equal_in ? ST_HIT_EQUAL : ST_HIT_NOT_EQUAL;
                        result.hit_offset = hit_pos_in;
                        scan_in           = 1'b0;
                     end else if (last_sector) begin
                        result.status = ST_DONE_NO_HIT;
                        scan_in       = 1'b0;
                     end else begin
                        result.status = ST_NO_HIT;
                        if (!(&count_ff)) begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= 1'b0;
         sign_ff      <= SIGN_EQUAL;
         hit_ff       <= 1'b0;
         hit_equal_ff <= 1'b0;
         hit_pos_ff   <= '0;
         count_ff     <= '0;
      end else begin
         scan_ff      <= scan_in;
         sign_ff      <= sign_in;
         hit_ff       <= hit_in;
         hit_equal_ff <= hit_equal_in;
         hit_pos_ff   <= hit_pos_in;
         count_ff     <= count_in;
      end
   end

endmodule

FILE: hdl/disk_sector_key_scan.sv
// Disk key-search scan engine.
// Input queue (push, full, req_item): load argument bytes, start a scan, then
// stream sector bytes, 256 to a sector. An item is taken at a clock edge with
// push high and full low. Results leave through an output queue (empty, pop,
// rsp_item): the oldest result is shown while empty is low and is taken at an
// edge with pop high. One result comes for each refused start and at the end
// of every scanned sector.
// Throughput is one item per cycle while full is low; results pass the front
// part's held register and the two queues. The front part classifies each
// sector byte against the key layout and reads the argument store, which
// has one registered read port; the back part compares and reports.
// When pop stays low, the output queue and then the two-entry queue between
// front and back fill, and full rises; nothing is dropped.
// Reset empties both queues, stops any scan and sets the registers to their
// defaults; the argument store holds nothing defined until it is loaded.
// Registers on the APB-style port lie at byte addresses 0, 4, ..., 20.
module disk_sector_key_scan #(
   parameter int SectorCountBits = dsks_pkg::SECTOR_COUNT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  dsks_pkg::req_item_type               req_item,
   output logic                                 empty,
   input  logic                                 pop,
   output dsks_pkg::rsp_item_type               rsp_item,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [dsks_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [dsks_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [dsks_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready
);
   import dsks_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_index;
   logic          csr_write;

   logic          work_push, work_full, work_empty, work_pop;
   work_item_type work_in_item, work_out_item;
   logic          rsp_push, rsp_full;
   rsp_item_type  rsp_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   // Register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_index)
            REG_FIRST_KEY:    cfg_in.first_key              = pwdata[7:0];
            REG_KEY_LENGTH:   cfg_in.key_length_minus_one   = pwdata[7:0];
            REG_LAST_KEY:     cfg_in.last_key               = pwdata[7:0];
            REG_KEY_GAP:      cfg_in.key_gap                = pwdata[7:0];
            REG_RELATION:     cfg_in.relation               = relation_type'(pwdata[1:0]);
            REG_SCAN_SECTORS: cfg_in.scan_sectors_minus_one = pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Register reads.
   always_comb begin
      case (reg_index)
         REG_FIRST_KEY:    prdata = {24'd0, cfg_ff.first_key};
         REG_KEY_LENGTH:   prdata = {24'd0, cfg_ff.key_length_minus_one};
         REG_LAST_KEY:     prdata = {24'd0, cfg_ff.last_key};
         REG_KEY_GAP:      prdata = {24'd0, cfg_ff.key_gap};
         REG_RELATION:     prdata = {30'd0, cfg_ff.relation};
         REG_SCAN_SECTORS: prdata = {16'd0, cfg_ff.scan_sectors_minus_one};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_key              <= '0;
         cfg_ff.key_length_minus_one   <= '0;
         cfg_ff.last_key               <= 8'd255;
         cfg_ff.key_gap                <= '0;
         cfg_ff.relation               <= REL_EQUAL;
         cfg_ff.scan_sectors_minus_one <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dsks_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .work_push (work_push),
      .work_item (work_in_item),
      .work_full (work_full)
   );

   // Short queue between the front and back parts.
   dsks_fifo #(
      .Width ($bits(work_item_type)),
      .Depth (QUEUE_DEPTH)
   ) u_work_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (work_push),
      .wr_data  (work_in_item),
      .is_full  (work_full),
      .rd_en    (work_pop),
      .rd_data  (work_out_item),
      .is_empty (work_empty)
   );

   dsks_back #(
      .SectorCountBits (SectorCountBits)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .work_empty (work_empty),
      .work_item  (work_out_item),
      .work_pop   (work_pop),
      .rsp_push   (rsp_push),
      .rsp_data   (rsp_data),
      .rsp_full   (rsp_full)
   );

   // Result queue toward the receiver.
   dsks_fifo #(
      .Width ($bits(rsp_item_type)),
      .Depth (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (rsp_push),
      .wr_data  (rsp_data),
      .is_full  (rsp_full),
      .rd_en    (pop),
      .rd_data  (rsp_item),
      .is_empty (empty)
   );

endmodule

FILE: verif/disk_sector_key_scan_tb.sv
module disk_sector_key_scan_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dsks_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int PRINT_CAP     = 40;
   localparam int ARG_LOADS     = 16;

   // Action code the block leaves unused.
   localparam action_type ACT_UNUSED = action_type'(2'd3);

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic clock   = 1'b0;
   logic reset   = 1'b1;
   logic push    = 1'b0;
   logic pop     = 1'b0;
   logic psel    = 1'b0;
   logic penable = 1'b0;
   logic pwrite  = 1'b0;
   logic full;
   logic empty;
   logic pready;
   req_item_type             req_item = '0;
   rsp_item_type             rsp_item;
   logic [CSR_ADDR_BITS-1:0] paddr  = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;

   // Items waiting to be offered, and scan results waiting to be seen.
   req_item_type scan_items_pending [$];
   rsp_item_type scan_results_due [$];

   int send_idle_pct  = 0;
   int take_stall_pct = 0;
   bit hold_results   = 1'b0;
   bit req_taken      = 1'b0;
   int mismatch_count = 0;

   // Predicted register contents and engine state.
   cfg_type    cfg;
   logic [7:0] arg_store [SECTOR_BYTES];
   int         byte_pos    = 0;
   int         next_start  = 0;
   int         key_idx     = 0;
   sign_type   cmp_sign    = SIGN_EQUAL;
   bit         key_open    = 1'b0;
   bit         hit_found   = 1'b0;
   bit         hit_eq      = 1'b0;
   bit         scanning    = 1'b0;
   logic [7:0] hit_pos     = '0;
   logic [15:0] sector_idx = '0;

   // Argument bytes as the stimulus plans them, ahead of acceptance.
   logic [7:0] arg_plan [SECTOR_BYTES];

   disk_sector_key_scan dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (mismatch_count < PRINT_CAP) begin
         $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   function automatic void restart_sector();
      byte_pos   = 0;
      next_start = int'(cfg.first_key);
      key_open   = 1'b0;
      key_idx    = 0;
      cmp_sign   = SIGN_EQUAL;
   endfunction

   // Advance the engine by one accepted item and queue the result it causes.
   function automatic void predict_scan_item(input req_item_type it);
      int           klen;
      int           nxt;
      bit           met;
      rsp_item_type r;
      klen = int'(cfg.key_length_minus_one) + 1;
      r = '0;
      case (it.action)
         ACT_LOAD: begin
            arg_store[it.argument_index] = it.data_byte;
         end
         ACT_START: begin
            if (cfg.relation == REL_REFUSED || int'(cfg.first_key) + klen > SECTOR_BYTES) begin
               scanning = 1'b0;
               r.status = ST_REFUSED;
               scan_results_due.push_back(r);
            end else begin
               scanning   = 1'b1;
               hit_found  = 1'b0;
               hit_eq     = 1'b0;
               hit_pos    = '0;
               sector_idx = '0;
               restart_sector();
            end
         end
         ACT_DATA: begin
            if (scanning) begin
               // A key opens only at its planned offset and only if it still fits.
               if (!hit_found && !key_open && byte_pos == next_start &&
                   next_start <= int'(cfg.last_key) && next_start + klen <= SECTOR_BYTES) begin
                  key_open = 1'b1;
                  key_idx  = 0;
                  cmp_sign = SIGN_EQUAL;
               end
               if (key_open) begin
                  // The first unequal byte decides the sign of the whole key.
                  if (cmp_sign == SIGN_EQUAL) begin
                     if (it.data_byte < arg_store[key_idx & 255]) cmp_sign = SIGN_LOW;
                     else if (it.data_byte > arg_store[key_idx & 255]) cmp_sign = SIGN_HIGH;
                  end
                  key_idx = (key_idx + 1) & 511;
                  if (key_idx >= klen) begin
                     nxt        = next_start + klen + int'(cfg.key_gap);
                     key_open   = 1'b0;
                     next_start = (nxt > 511) ? 511 : nxt;
                     case (cfg.relation)
                        REL_EQUAL:      met = (cmp_sign == SIGN_EQUAL);
                        REL_LOW_EQUAL:  met = (cmp_sign != SIGN_HIGH);
                        REL_HIGH_EQUAL: met = (cmp_sign != SIGN_LOW);
                        default:        met = 1'b0;
                     endcase
                     if (met) begin
                        hit_found = 1'b1;
                        hit_eq    = (cmp_sign == SIGN_EQUAL);
                        hit_pos   = 8'(byte_pos);
                     end
                  end
               end
               // The last byte of a sector closes it with a result.
               if (byte_pos < SECTOR_BYTES - 1) begin
                  byte_pos++;
               end else begin
                  r.sector_offset = sector_idx;
                  if (hit_found) begin
                     r.status     = hit_eq ? ST_HIT_EQUAL : ST_HIT_NOT_EQUAL;
                     r.hit_offset = hit_pos;
                     scanning     = 1'b0;
                  end else if (sector_idx == cfg.scan_sectors_minus_one) begin
                     r.status = ST_DONE_NO_HIT;
                     scanning = 1'b0;
                  end else begin
                     r.status = ST_NO_HIT;
                     if (sector_idx != 16'hFFFF) sector_idx++;
                  end
                  scan_results_due.push_back(r);
                  restart_sector();
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Input side: hold an offer until it is taken, otherwise offer the next item.
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (!(push && !req_taken)) begin
         if (scan_items_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            push     <= 1'b1;
            req_item <= scan_items_pending[0];
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Result side: random stalls, plus the long hold-off when it is requested.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         pop <= !hold_results && ($urandom_range(99) >= take_stall_pct);
      end
   end

   // Sample both handshakes at the rising edge.
   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = push && !full;
         if (req_taken) begin
            predict_scan_item(req_item);
            void'(scan_items_pending.pop_front());
         end
         if (pop && !empty) begin
            if (scan_results_due.size() == 0) begin
               report_mismatch("result with none due, status", int'(rsp_item.status), -1);
            end else begin
               want = scan_results_due.pop_front();
               if (rsp_item.status !== want.status) begin
                  report_mismatch("status", int'(rsp_item.status), int'(want.status));
               end
               if (rsp_item.hit_offset !== want.hit_offset) begin
                  report_mismatch("hit_offset", int'(rsp_item.hit_offset),
                                  int'(want.hit_offset));
               end
               if (rsp_item.sector_offset !== want.sector_offset) begin
                  report_mismatch("sector_offset", int'(rsp_item.sector_offset),
                                  int'(want.sector_offset));
               end
            end
         end
      end
   end

   function automatic void add_item(input action_type act, input logic [7:0] idx,
                                    input logic [7:0] value);
      req_item_type it;
      it.action         = act;
      it.argument_index = idx;
      it.data_byte      = value;
      if (act == ACT_LOAD) arg_plan[idx] = value;
      scan_items_pending.push_back(it);
   endfunction

   // Wait until every item is taken and every result seen, then let the pipe empty.
   task automatic drain();
      while (scan_items_pending.size() != 0 || scan_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write one register, then read it back.
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] mask;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_FIRST_KEY:    begin cfg.first_key = value[7:0]; mask = 32'hFF; end
         REG_KEY_LENGTH:   begin cfg.key_length_minus_one = value[7:0]; mask = 32'hFF; end
         REG_LAST_KEY:     begin cfg.last_key = value[7:0]; mask = 32'hFF; end
         REG_KEY_GAP:      begin cfg.key_gap = value[7:0]; mask = 32'hFF; end
         REG_RELATION:     begin cfg.relation = relation_type'(value[1:0]); mask = 32'h3; end
         REG_SCAN_SECTORS: begin cfg.scan_sectors_minus_one = value[15:0]; mask = 32'hFFFF; end
         default:          mask = '0;
      endcase
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== (value & mask)) begin
         report_mismatch("register readback", int'(prdata), int'(value & mask));
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Settle the block, program every register and pick the idling pattern.
   task automatic begin_phase(input idle_mode_type mode, input logic [7:0] fk,
                              input logic [7:0] klm, input logic [7:0] lk,
                              input logic [7:0] gap, input relation_type rel,
                              input logic [15:0] sectors);
      drain();
      write_register(REG_FIRST_KEY, 32'(fk));
      write_register(REG_KEY_LENGTH, 32'(klm));
      write_register(REG_LAST_KEY, 32'(lk));
      write_register(REG_KEY_GAP, 32'(gap));
      write_register(REG_RELATION, 32'(rel));
      write_register(REG_SCAN_SECTORS, 32'(sectors));
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  take_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 74; take_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  take_stall_pct = 74; end
         default:       begin send_idle_pct = 20; take_stall_pct = 20; end
      endcase
   endtask

   // Queue the bytes of one sector. Keys are built from the argument so that
   // the planned key hits and the others miss under the current relation.
   task automatic plan_sector(input bit want_hit, input int length);
      int         klen;
      int         pos;
      int         d;
      int         dir;
      int         k;
      int         j;
      int         hit_key;
      int         key_start [$];
      logic [7:0] key_bytes [SECTOR_BYTES];
      bit         moved;
      klen = int'(cfg.key_length_minus_one) + 1;
      pos  = int'(cfg.first_key);
      while (pos <= int'(cfg.last_key) && pos + klen <= SECTOR_BYTES) begin
         key_start.push_back(pos);
         pos += klen + int'(cfg.key_gap);
      end
      hit_key = (want_hit && key_start.size() > 0) ?
                int'($urandom_range(key_start.size() - 1)) : -1;
      k = 0;
      j = -1;
      for (pos = 0; pos < length; pos++) begin
         // Build the whole key when its first byte comes up.
         if (k < key_start.size() && pos == key_start[k]) begin
            for (int b = 0; b < klen; b++) key_bytes[b] = arg_plan[b];
            d = int'($urandom_range(klen - 1));
            case (cfg.relation)
               REL_EQUAL:      dir = (k == hit_key) ? 0 : 2;
               REL_LOW_EQUAL:  dir = (k == hit_key) ? -int'($urandom_range(1)) : 1;
               REL_HIGH_EQUAL: dir = (k == hit_key) ? int'($urandom_range(1)) : -1;
               default:        dir = 2;
            endcase
            moved = 1'b1;
            if (dir == -1 && arg_plan[d] != 8'd0) begin
               key_bytes[d] = 8'($urandom_range(int'(arg_plan[d]) - 1, 0));
            end else if (dir == 1 && arg_plan[d] != 8'hFF) begin
               key_bytes[d] = 8'($urandom_range(255, int'(arg_plan[d]) + 1));
            end else if (dir == 2) begin
               key_bytes[d] = arg_plan[d] ^ 8'($urandom_range(255, 1));
            end else begin
               moved = 1'b0;
            end
            // Bytes after the deciding one no longer change the outcome.
            if (moved) begin
               for (int b = d + 1; b < klen; b++) key_bytes[b] = 8'($urandom);
            end
            j = 0;
         end
         if (j >= 0) begin
            add_item(ACT_DATA, 8'($urandom), key_bytes[j]);
            j++;
            if (j == klen) begin
               j = -1;
               k++;
            end
         end else begin
            add_item(ACT_DATA, 8'($urandom), 8'($urandom));
         end
      end
   endtask

   // One scan: a start and up to the given number of sectors. Some scans are
   // cut short mid-sector, and some get argument reloads between sectors.
   task automatic plan_scan(input int sectors);
      bit hit;
      if ($urandom_range(9) == 0) begin
         add_item(action_type'(2'($urandom_range(3))), 8'($urandom), 8'($urandom));
      end
      add_item(ACT_START, 8'($urandom), 8'($urandom));
      for (int s = 0; s < sectors; s++) begin
         if ($urandom_range(7) == 0) begin
            add_item(ACT_LOAD, 8'($urandom_range(int'(cfg.key_length_minus_one))),
                     8'($urandom));
         end
         if ($urandom_range(11) == 0) begin
            plan_sector(1'b0, int'($urandom_range(SECTOR_BYTES - 1, 1)));
            return;
         end
         hit = ($urandom_range(2) == 0);
         plan_sector(hit, SECTOR_BYTES);
         if (hit) return;
      end
   endtask

   // Run-time limit.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      logic [7:0]   fk;
      logic [7:0]   klm;
      logic [7:0]   lk;
      logic [7:0]   gap;
      relation_type rel;
      logic [15:0]  sectors;
      cfg = '0;
      cfg.last_key = 8'hFF;
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Defaults, the argument bytes the keys use, ignored items and a restarted scan.
      begin_phase(IDLE_NONE, 8'd0, 8'd0, 8'd255, 8'd0, REL_EQUAL, 16'd0);
      for (int i = 0; i < ARG_LOADS; i++) add_item(ACT_LOAD, 8'(i), 8'($urandom));
      add_item(ACT_DATA, 8'hFF, 8'h00);
      add_item(ACT_UNUSED, 8'h00, 8'hFF);
      add_item(ACT_START, 8'h00, 8'h00);
      plan_sector(1'b0, 40);
      add_item(ACT_START, 8'h00, 8'h00);
      plan_sector(1'b0, 30);

      // A key one byte past the sector end is refused; data after it is ignored.
      begin_phase(IDLE_SENDER, 8'd255, 8'd1, 8'd255, 8'd255, REL_EQUAL, 16'd2);
      for (int i = 0; i < 3; i++) begin
         add_item(ACT_START, 8'h55, 8'hAA);
         add_item(ACT_DATA, 8'hAA, 8'h55);
      end

      // Refusals pile up while the result side holds off, so the input stalls.
      begin_phase(IDLE_RECEIVER, 8'd0, 8'd0, 8'd255, 8'd0, REL_REFUSED, 16'd0);
      fork
         begin
            hold_results = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end
      join_none
      for (int i = 0; i < 24; i++) begin
         add_item(ACT_START, 8'($urandom), 8'($urandom));
         if (i % 6 == 0) add_item(ACT_LOAD, 8'($urandom), 8'($urandom));
      end

      // One full scan with random geometry; keys stay within the loaded argument.
      fk      = 8'($urandom_range(40));
      klm     = 8'($urandom_range(ARG_LOADS - 1));
      lk      = ($urandom_range(1) == 0) ? 8'd255 : 8'($urandom);
      gap     = 8'($urandom_range(5));
      rel     = relation_type'(2'($urandom_range(2)));
      sectors = 16'($urandom_range(1));
      begin_phase(IDLE_BOTH, fk, klm, lk, gap, rel, sectors);
      plan_scan(1);
      // Bytes that run on into a second sector or reach an idle engine.
      plan_sector(1'b0, int'($urandom_range(40, 1)));

      drain();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
